FILE: rtl/core/sssc_pkg.sv
// Shared types and constants for the stepper speed and steering controller.
// No dependencies; imported by the top level.
package sssc_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_RSTEP = 2'd2,
        OP_LSTEP = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROF,
        S_MUL,
        S_DSET,
        S_DIV,
        S_DFIN,
        S_DONE
    } ctrl_state_t;

    // configuration register indexes
    localparam logic [2:0] REG_CONTROL_MODE    = 3'd0;
    localparam logic [2:0] REG_ACCEL_STEP      = 3'd1;
    localparam logic [2:0] REG_SPEED_LIMIT     = 3'd2;
    localparam logic [2:0] REG_RIGHT_REFERENCE = 3'd3;
    localparam logic [2:0] REG_LEFT_REFERENCE  = 3'd4;
    localparam logic [2:0] REG_RIGHT_THRESHOLD = 3'd5;
    localparam logic [2:0] REG_LEFT_THRESHOLD  = 3'd6;
    localparam logic [2:0] REG_STEER_GAIN      = 3'd7;

    localparam logic [1:0] PROF_ACCEL = 2'd1;
    localparam logic [1:0] PROF_DECEL = 2'd2;

    localparam logic [15:0] SPEED_LIMIT_RST = 16'd19200;

    // 3000000 / (v / 0.377) with v in Q10.6 mm/s: 1131000 * 64
    localparam int          NUM_W            = 27;
    localparam int          CNT_W            = $clog2(NUM_W);
    localparam logic [NUM_W-1:0] PERIOD_NUMERATOR = 27'd72384000;

endpackage

FILE: rtl/core/stepper_speed_steering_control_top.sv
// Stepper speed profile and wall-following steering controller, top level.
// Start and step: from IDLE to DONE, then the result goes into the output register.
// Control tick: profile, steering product, then the shared restoring divider run twice,
// once per wheel period (skipped when the divisor is not positive), then DONE.
// One transaction in flight; a result left waiting in the output register holds
// off the next one. Synchronous active-low reset: speed, counters and goal to
// zero, held periods to all ones, speed_limit to 19200, other config and valid to zero.
module stepper_speed_steering_control_top
    import sssc_pkg::*;
#(
    parameter int PERIOD_WIDTH = 16,
    parameter int SENSOR_WIDTH = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // start_speed[15:0], step_goal[31:16], right_sensor[43:32], left_sensor[55:44]
    input  logic [55:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // right_period[15:0], left_period[31:16], speed_now[47:32], move_done[48]
    output logic [55:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int DIFF_W = SENSOR_WIDTH + 3;
    localparam int P_W    = SENSOR_WIDTH + 12;
    localparam int DV_W   = P_W + 1;
    localparam logic [32:0] PERIOD_MAX_EXT = (33'd1 << PERIOD_WIDTH) - 33'd1;

    ctrl_state_t state_reg, state_next;

    logic [2:0]  mode_reg,  mode_next;
    logic [15:0] accel_reg, accel_next;
    logic [15:0] limit_reg, limit_next;
    logic [11:0] rref_reg,  rref_next;
    logic [11:0] lref_reg,  lref_next;
    logic [11:0] rthr_reg,  rthr_next;
    logic [11:0] lthr_reg,  lthr_next;
    logic [7:0]  gain_reg,  gain_next;

    logic [15:0] speed_reg,  speed_next;
    logic [15:0] rsteps_reg, rsteps_next;
    logic [15:0] lsteps_reg, lsteps_next;
    logic [15:0] goal_reg,   goal_next;
    logic [PERIOD_WIDTH-1:0] rhold_reg, rhold_next;
    logic [PERIOD_WIDTH-1:0] lhold_reg, lhold_next;

    logic [SENSOR_WIDTH-1:0] rs_reg, rs_next;
    logic [SENSOR_WIDTH-1:0] ls_reg, ls_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic signed [P_W-1:0]    p_reg,    p_next;
    logic [DV_W-1:0]  div_reg, div_next;
    logic [DV_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             left_side_reg, left_side_next;
    logic             sat_reg, sat_next;

    logic        m_valid_reg, m_valid_next;
    logic [55:0] m_data_reg,  m_data_next;

    logic    in_fire;
    opcode_t op_in;
    logic [15:0] rs_in16, ls_in16, rref16, lref16, rthr16, lthr16;
    logic [SENSOR_WIDTH-1:0] rref_m, lref_m, rthr_m, lthr_m;
    logic        rpres, lpres;
    logic signed [SENSOR_WIDTH:0]   dr, dl;
    logic signed [SENSOR_WIDTH+1:0] dsum;
    logic signed [DIFF_W-1:0]       dscaled;
    logic signed [P_W-1:0]          prod;
    logic signed [DV_W-1:0]         spd_ext, p_ext, dv;
    logic [DV_W:0]   shifted, div_cmp;
    logic            ge;
    logic [PERIOD_WIDTH-1:0] hold_val;
    logic [16:0] step_sum;
    logic        move_done;
    logic [31:0] rh32, lh32;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign op_in   = opcode_t'(s_axis_tuser);

    assign rs_in16 = 16'(s_axis_tdata[43:32]);
    assign ls_in16 = 16'(s_axis_tdata[55:44]);
    assign rref16  = 16'(rref_reg);
    assign lref16  = 16'(lref_reg);
    assign rthr16  = 16'(rthr_reg);
    assign lthr16  = 16'(lthr_reg);
    assign rref_m  = rref16[SENSOR_WIDTH-1:0];
    assign lref_m  = lref16[SENSOR_WIDTH-1:0];
    assign rthr_m  = rthr16[SENSOR_WIDTH-1:0];
    assign lthr_m  = lthr16[SENSOR_WIDTH-1:0];

    // steering error, doubled when a wall is missing
    assign rpres = rs_reg > rthr_m;
    assign lpres = ls_reg > lthr_m;
    assign dr = rpres ? ($signed({1'b0, rs_reg}) - $signed({1'b0, rref_m})) : '0;
    assign dl = lpres ? ($signed({1'b0, lref_m}) - $signed({1'b0, ls_reg})) : '0;
    assign dsum = {dr[SENSOR_WIDTH], dr} + {dl[SENSOR_WIDTH], dl};
    assign dscaled = (rpres && lpres) ? {dsum[SENSOR_WIDTH+1], dsum} : {dsum, 1'b0};

    assign prod = P_W'(diff_reg) * P_W'($signed({1'b0, gain_reg}));

    assign spd_ext = $signed(DV_W'(speed_reg));
    assign p_ext   = {p_reg[P_W-1], p_reg};
    assign dv      = left_side_reg ? (spd_ext - p_ext) : (spd_ext + p_ext);

    // one restoring divider step
    assign shifted = {rem_reg, PERIOD_NUMERATOR[cnt_reg]};
    assign div_cmp = {1'b0, div_reg};
    assign ge      = shifted >= div_cmp;

    assign hold_val = (sat_reg || (33'(quo_reg) > PERIOD_MAX_EXT)) ?
                      '1 : PERIOD_WIDTH'(quo_reg);

    assign step_sum  = {1'b0, rsteps_reg} + {1'b0, lsteps_reg};
    assign move_done = step_sum >= {1'b0, goal_reg};
    assign rh32 = 32'(rhold_reg);
    assign lh32 = 32'(lhold_reg);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        accel_next     = accel_reg;
        limit_next     = limit_reg;
        rref_next      = rref_reg;
        lref_next      = lref_reg;
        rthr_next      = rthr_reg;
        lthr_next      = lthr_reg;
        gain_next      = gain_reg;
        speed_next     = speed_reg;
        rsteps_next    = rsteps_reg;
        lsteps_next    = lsteps_reg;
        goal_next      = goal_reg;
        rhold_next     = rhold_reg;
        lhold_next     = lhold_reg;
        rs_next        = rs_reg;
        ls_next        = ls_reg;
        diff_next      = diff_reg;
        p_next         = p_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        left_side_next = left_side_reg;
        sat_next       = sat_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_we) begin
            case (cfg_addr)
                REG_CONTROL_MODE:    mode_next  = cfg_wdata[2:0];
                REG_ACCEL_STEP:      accel_next = cfg_wdata;
                REG_SPEED_LIMIT:     limit_next = cfg_wdata;
                REG_RIGHT_REFERENCE: rref_next  = cfg_wdata[11:0];
                REG_LEFT_REFERENCE:  lref_next  = cfg_wdata[11:0];
                REG_RIGHT_THRESHOLD: rthr_next  = cfg_wdata[11:0];
                REG_LEFT_THRESHOLD:  lthr_next  = cfg_wdata[11:0];
                REG_STEER_GAIN:      gain_next  = cfg_wdata[7:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    state_next = S_DONE;
                    case (op_in)
                        OP_START: begin
                            speed_next  = s_axis_tdata[15:0];
                            goal_next   = s_axis_tdata[31:16];
                            rsteps_next = '0;
                            lsteps_next = '0;
                        end
                        OP_TICK: begin
                            rs_next        = rs_in16[SENSOR_WIDTH-1:0];
                            ls_next        = ls_in16[SENSOR_WIDTH-1:0];
                            left_side_next = 1'b0;
                            state_next     = S_PROF;
                        end
                        OP_RSTEP: begin
                            if (rsteps_reg != 16'hFFFF) begin
                                rsteps_next = rsteps_reg + 16'd1;
                            end
                        end
                        OP_LSTEP: begin
                            if (lsteps_reg != 16'hFFFF) begin
                                lsteps_next = lsteps_reg + 16'd1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PROF: begin
                case (mode_reg[1:0])
                    PROF_ACCEL: begin
                        if (speed_reg < limit_reg) begin
                            speed_next = (accel_reg > (limit_reg - speed_reg)) ?
                                         limit_reg : (speed_reg + accel_reg);
                        end
                    end
                    PROF_DECEL: begin
                        if (speed_reg > limit_reg) begin
                            speed_next = (accel_reg > (speed_reg - limit_reg)) ?
                                         limit_reg : (speed_reg - accel_reg);
                        end
                    end
                    default: ;
                endcase
                diff_next  = mode_reg[2] ? dscaled : '0;
                state_next = S_MUL;
            end
            S_MUL: begin
                p_next     = prod;
                state_next = S_DSET;
            end
            S_DSET: begin
                if (dv[DV_W-1] || (dv == '0)) begin
                    sat_next   = 1'b1;
                    state_next = S_DFIN;
                end else begin
                    sat_next   = 1'b0;
                    div_next   = dv;
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = CNT_W'(NUM_W - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                rem_next = ge ? DV_W'(shifted - div_cmp) : DV_W'(shifted);
                quo_next = {quo_reg[NUM_W-2:0], ge};
                if (cnt_reg == '0) begin
                    state_next = S_DFIN;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_DFIN: begin
                if (left_side_reg) begin
                    lhold_next = hold_val;
                    state_next = S_DONE;
                end else begin
                    rhold_next     = hold_val;
                    left_side_next = 1'b1;
                    state_next     = S_DSET;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_data_next  = {7'd0, move_done, speed_reg, lh32[15:0], rh32[15:0]};
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mode_reg    <= '0;
            accel_reg   <= '0;
            limit_reg   <= SPEED_LIMIT_RST;
            rref_reg    <= '0;
            lref_reg    <= '0;
            rthr_reg    <= '0;
            lthr_reg    <= '0;
            gain_reg    <= '0;
            speed_reg   <= '0;
            rsteps_reg  <= '0;
            lsteps_reg  <= '0;
            goal_reg    <= '0;
            rhold_reg   <= '1;
            lhold_reg   <= '1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            accel_reg   <= accel_next;
            limit_reg   <= limit_next;
            rref_reg    <= rref_next;
            lref_reg    <= lref_next;
            rthr_reg    <= rthr_next;
            lthr_reg    <= lthr_next;
            gain_reg    <= gain_next;
            speed_reg   <= speed_next;
            rsteps_reg  <= rsteps_next;
            lsteps_reg  <= lsteps_next;
            goal_reg    <= goal_next;
            rhold_reg   <= rhold_next;
            lhold_reg   <= lhold_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rs_reg        <= rs_next;
        ls_reg        <= ls_next;
        diff_reg      <= diff_next;
        p_reg         <= p_next;
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
        left_side_reg <= left_side_next;
        sat_reg       <= sat_next;
        m_data_reg    <= m_data_next;
    end

    // busy once an item is accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_axis_tready)
        else $error("input accepted while a transaction is in progress");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && !in_fire) |=> $stable(speed_reg))
        else $error("speed changed without a transaction");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROF && mode_reg[1:0] == PROF_ACCEL && !cfg_we &&
         speed_reg <= limit_reg) |=> (speed_reg <= limit_reg))
        else $error("acceleration passed the speed limit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (!div_reg[DV_W-1] && div_reg != '0))
        else $error("divider running with a non-positive divisor");

endmodule

FILE: tb/sv/speed_steer_monitor.sv
// Watches the item, result and register-write ports of the stepper speed and
// steering controller, predicts each result and compares it field by field.
// Depends on sssc_pkg for the opcode type, register indexes and constants.
`timescale 1ns / 100ps

module speed_steer_monitor
    import sssc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          n_accepted,
    output int          n_checked
);

    localparam logic [15:0] PERIOD_SAT = 16'hFFFF;

    typedef struct packed {
        logic [15:0] right_period;
        logic [15:0] left_period;
        logic [15:0] speed_now;
        logic        move_done;
    } wheel_result_t;

    wheel_result_t expected_results[$];
    wheel_result_t want, got, pred;

    // register copies
    logic [2:0]  mode;
    logic [15:0] accel, limit;
    logic [11:0] rref, lref, rthr, lthr;
    logic [7:0]  gain;

    // controller state
    logic [15:0] speed, goal, rsteps, lsteps, rhold, lhold;

    function automatic logic [15:0] period_for(longint divisor);
        longint quot;
        if (divisor <= 0) return PERIOD_SAT;
        quot = longint'(PERIOD_NUMERATOR) / divisor;
        if (quot > 65535) return PERIOD_SAT;
        return quot[15:0];
    endfunction

    task automatic apply_item(input opcode_t op, input logic [15:0] spd, gl,
                              input logic [11:0] rs, ls, output wheel_result_t r);
        logic [16:0] raised, step_sum;
        longint lowered, lim_l, acc_l, base, dr, dl, scale, corr, a, b;
        case (op)
            OP_START: begin
                speed  = spd;
                goal   = gl;
                rsteps = '0;
                lsteps = '0;
            end
            OP_TICK: begin
                if (mode[1:0] == PROF_ACCEL) begin
                    if (speed < limit) begin
                        raised = {1'b0, speed} + {1'b0, accel};
                        speed  = (raised > {1'b0, limit}) ? limit : raised[15:0];
                    end
                end else if (mode[1:0] == PROF_DECEL) begin
                    if (speed > limit) begin
                        lowered = longint'(speed);
                        acc_l   = longint'(accel);
                        lim_l   = longint'(limit);
                        lowered = lowered - acc_l;
                        speed   = (lowered < lim_l) ? limit : lowered[15:0];
                    end
                end
                corr = 0;
                if (mode[2]) begin
                    scale = 1;
                    dr    = 0;
                    dl    = 0;
                    if (rs > rthr) begin
                        a  = longint'(rs);
                        b  = longint'(rref);
                        dr = a - b;
                    end else begin
                        scale = 2;
                    end
                    if (ls > lthr) begin
                        a  = longint'(lref);
                        b  = longint'(ls);
                        dl = a - b;
                    end else begin
                        scale = 2;
                    end
                    a    = longint'(gain);
                    corr = (dl + dr) * scale * a;
                end
                base  = longint'(speed);
                rhold = period_for(base + corr);
                lhold = period_for(base - corr);
            end
            OP_RSTEP: begin
                if (rsteps != 16'hFFFF) rsteps = rsteps + 16'd1;
            end
            OP_LSTEP: begin
                if (lsteps != 16'hFFFF) lsteps = lsteps + 16'd1;
            end
            default: ;
        endcase
        step_sum       = {1'b0, rsteps} + {1'b0, lsteps};
        r.right_period = rhold;
        r.left_period  = lhold;
        r.speed_now    = speed;
        r.move_done    = (step_sum >= {1'b0, goal});
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            mode   = '0;
            accel  = '0;
            limit  = SPEED_LIMIT_RST;
            rref   = '0;
            lref   = '0;
            rthr   = '0;
            lthr   = '0;
            gain   = '0;
            speed  = '0;
            goal   = '0;
            rsteps = '0;
            lsteps = '0;
            rhold  = PERIOD_SAT;
            lhold  = PERIOD_SAT;
            expected_results.delete();
            fail_count = 0;
            n_accepted <= 0;
            n_checked  <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_checked <= n_checked + 1;
                got.right_period = m_axis_tdata[15:0];
                got.left_period  = m_axis_tdata[31:16];
                got.speed_now    = m_axis_tdata[47:32];
                got.move_done    = m_axis_tdata[48];
                if (expected_results.size() == 0) begin
                    $error("result transaction with no expected result");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("right_period", int'(want.right_period),
                                int'(got.right_period));
                    check_field("left_period", int'(want.left_period),
                                int'(got.left_period));
                    check_field("speed_now", int'(want.speed_now), int'(got.speed_now));
                    check_field("move_done", int'(want.move_done), int'(got.move_done));
                end
            end
            if (cfg_we) begin
                case (cfg_addr)
                    REG_CONTROL_MODE:    mode  = cfg_wdata[2:0];
                    REG_ACCEL_STEP:      accel = cfg_wdata;
                    REG_SPEED_LIMIT:     limit = cfg_wdata;
                    REG_RIGHT_REFERENCE: rref  = cfg_wdata[11:0];
                    REG_LEFT_REFERENCE:  lref  = cfg_wdata[11:0];
                    REG_RIGHT_THRESHOLD: rthr  = cfg_wdata[11:0];
                    REG_LEFT_THRESHOLD:  lthr  = cfg_wdata[11:0];
                    REG_STEER_GAIN:      gain  = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                apply_item(opcode_t'(s_axis_tuser), s_axis_tdata[15:0], s_axis_tdata[31:16],
                           s_axis_tdata[43:32], s_axis_tdata[55:44], pred);
                expected_results.push_back(pred);
                n_accepted <= n_accepted + 1;
            end
        end
    end

endmodule

FILE: tb/sv/testbench.sv
// Top of the stepper speed and steering controller testbench: clock, reset,
// register writes, item and result traffic with random gaps, and the verdict.
// Depends on sssc_pkg, the block's top level and speed_steer_monitor.
`timescale 1ns / 100ps

module testbench;
    import sssc_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int N_PHASES      = 12;
    localparam int PHASE_ITEMS   = 128;
    localparam int SAT_STEPS     = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = OP_START;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = REG_CONTROL_MODE;
    logic [15:0] cfg_wdata = '0;

    int fail_count, n_accepted, n_checked;
    int cycle_count = 0;
    int hold_wanted = 0;
    int holds_done = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    stepper_speed_steering_control_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    speed_steer_monitor monitor (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .n_accepted    (n_accepted),
        .n_checked     (n_checked)
    );

    // one transaction; returns at the edge where it is accepted, tvalid still high
    task automatic send_item(input opcode_t op, input logic [15:0] spd, gl,
                             input logic [11:0] rs, ls);
        int gap;
        gap = $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {ls, rs, gl, spd};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic send_random(input opcode_t op);
        logic [15:0] spd, gl;
        spd = 16'($urandom_range(0, 65535));
        gl  = 16'($urandom_range(0, 65535));
        if (op == OP_START) begin
            if ($urandom_range(0, 1)) spd = 16'($urandom_range(0, 4000));
            if ($urandom_range(0, 4) != 0) gl = 16'($urandom_range(0, 60));
        end
        send_item(op, spd, gl, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_accepted != n_checked) @(posedge aclk);
    endtask

    // all eight registers, back to back; only called with the block drained
    task automatic set_config(input logic [2:0] md, input logic [15:0] acc, lim,
                              input logic [11:0] rr, lr, rt, lt, input logic [7:0] g);
        logic [15:0] vals [8];
        vals[REG_CONTROL_MODE]    = 16'(md);
        vals[REG_ACCEL_STEP]      = acc;
        vals[REG_SPEED_LIMIT]     = lim;
        vals[REG_RIGHT_REFERENCE] = 16'(rr);
        vals[REG_LEFT_REFERENCE]  = 16'(lr);
        vals[REG_RIGHT_THRESHOLD] = 16'(rt);
        vals[REG_LEFT_THRESHOLD]  = 16'(lt);
        vals[REG_STEER_GAIN]      = 16'(g);
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= i[2:0];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 2000));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [11:0] pick12();
        case ($urandom_range(0, 5))
            0:       return 12'd0;
            1:       return 12'hFFF;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // result side: random stall per transaction, plus long hold-offs on request
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            if (holds_done < hold_wanted) begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        int r;
        logic [2:0] md;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: held periods all ones, goal zero, zero divisor
        send_item(OP_RSTEP, 16'd0, 16'd0, 12'd0, 12'd0);
        send_item(OP_TICK, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF);
        send_item(OP_START, 16'hFFFF, 16'hFFFF, 12'd0, 12'd0);
        send_item(OP_TICK, 16'd0, 16'd0, 12'd0, 12'd0);
        send_item(OP_START, 16'd1, 16'd2, 12'hFFF, 12'd0);
        send_item(OP_TICK, 16'd0, 16'd0, 12'd0, 12'hFFF);
        send_item(OP_LSTEP, 16'd0, 16'd0, 12'd0, 12'd0);
        send_item(OP_RSTEP, 16'd0, 16'd0, 12'd0, 12'd0);
        drain();

        // acceleration clamped at the limit, then held there
        set_config({1'b0, PROF_ACCEL}, 16'hFFFF, 16'hFFFF, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0);
        send_item(OP_TICK, 16'd0, 16'd0, 12'd0, 12'd0);
        send_item(OP_TICK, 16'd0, 16'd0, 12'd0, 12'd0);
        drain();

        // deceleration to a zero limit, then held
        set_config({1'b0, PROF_DECEL}, 16'hFFFF, 16'd0, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0);
        send_item(OP_TICK, 16'd0, 16'd0, 12'd0, 12'd0);
        send_item(OP_TICK, 16'd0, 16'd0, 12'd0, 12'd0);
        send_item(OP_START, 16'd3000, 16'd0, 12'd0, 12'd0);
        send_item(OP_TICK, 16'd0, 16'd0, 12'd0, 12'd0);
        drain();

        // steering with each wall present or absent, threshold equality
        set_config(3'd7, 16'd100, 16'd1000, 12'd2048, 12'd2048, 12'd1000, 12'd1000, 8'hFF);
        send_item(OP_START, 16'd1000, 16'd4, 12'd0, 12'd0);
        send_item(OP_TICK, 16'd0, 16'd0, 12'hFFF, 12'hFFF);
        send_item(OP_TICK, 16'd0, 16'd0, 12'hFFF, 12'd0);
        send_item(OP_TICK, 16'd0, 16'd0, 12'd0, 12'hFFF);
        send_item(OP_TICK, 16'd0, 16'd0, 12'd0, 12'd0);
        send_item(OP_TICK, 16'd0, 16'd0, 12'd1000, 12'd1001);
        send_item(OP_TICK, 16'd0, 16'd0, 12'd1001, 12'd1000);
        drain();

        // step counters against a large goal
        set_config(3'd0, 16'd0, 16'd0, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0);
        send_item(OP_START, 16'd5000, 16'hFFFF, 12'd0, 12'd0);
        for (int i = 0; i < SAT_STEPS; i++) send_random(OP_RSTEP);
        for (int i = 0; i < SAT_STEPS; i++) send_random(OP_LSTEP);
        send_random(OP_TICK);
        drain();

        for (int k = 0; k < N_PHASES; k++) begin
            md = (k < 8) ? k[2:0] : 3'($urandom_range(0, 7));
            set_config(md, pick16(), pick16(), pick12(), pick12(), pick12(), pick12(),
                       ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
            send_random(OP_START);
            if (k == 3 || k == 9) hold_wanted <= hold_wanted + 1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                r = $urandom_range(0, 99);
                if (r < 8)       send_random(OP_START);
                else if (r < 50) send_random(OP_TICK);
                else if (r < 75) send_random(OP_RSTEP);
                else             send_random(OP_LSTEP);
            end
            drain();
        end

        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
